FILE: src/pfep_pkg.sv
package pfep_pkg;

  localparam int WORD_BITS   = 64;
  localparam int WID_W       = 7;
  localparam int FILL_W      = 6;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;
  localparam int REG_IDX_W   = 3;
  localparam int OUT_DATA_W  = 80;
  localparam int OUT_USER_W  = 3;

  localparam logic [WID_W-1:0] FULL_WIDTH = 7'd64;

  localparam logic [1:0] STREAM_MAIN = 2'd0;
  localparam logic [1:0] STREAM_LOW  = 2'd1;
  localparam logic [1:0] STREAM_HIGH = 2'd2;

  localparam logic KIND_CLASS = 1'b0;
  localparam logic KIND_WORD  = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_WINDOW_BASE  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LIMIT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GLOBAL_MIN   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAIN_WIDTH   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LOW_WIDTH    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_HIGH_WIDTH   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MIDDLE_MODE  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_LOW_ENABLED  = 3'd7;

  typedef struct packed {
    logic [1:0]           stream;
    logic                 in_window;
    logic                 below_base;
    logic                 overflow;
    logic [WORD_BITS-1:0] bits;
    logic [WID_W-1:0]     width;
    logic                 last;
  } item_t;

endpackage

FILE: src/pfep_front.sv
module pfep_front
  import pfep_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [WORD_BITS-1:0] cfg_wdata,
  input  logic [WORD_BITS-1:0] value,
  input  logic                 last_item,
  output item_t                item
);

  logic [WORD_BITS-1:0] window_base;
  logic [WORD_BITS-1:0] window_limit;
  logic [WORD_BITS-1:0] global_minimum;
  logic [WID_W-1:0]     main_width;
  logic [WID_W-1:0]     low_width;
  logic [WID_W-1:0]     high_width;
  logic                 middle_mode;
  logic                 low_enabled;

  logic                 in_win;
  logic                 go_low;
  logic [WORD_BITS-1:0] offset;
  logic [WORD_BITS-1:0] diff;
  logic [WID_W-1:0]     w_raw;
  logic [WID_W-1:0]     w_clamp;
  logic [WORD_BITS-1:0] mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_base    <= '0;
      window_limit   <= '0;
      global_minimum <= '0;
      main_width     <= '0;
      low_width      <= '0;
      high_width     <= '0;
      middle_mode    <= 1'b0;
      low_enabled    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_BASE:  window_base    <= cfg_wdata;
        REG_WINDOW_LIMIT: window_limit   <= cfg_wdata;
        REG_GLOBAL_MIN:   global_minimum <= cfg_wdata;
        REG_MAIN_WIDTH:   main_width     <= cfg_wdata[WID_W-1:0];
        REG_LOW_WIDTH:    low_width      <= cfg_wdata[WID_W-1:0];
        REG_HIGH_WIDTH:   high_width     <= cfg_wdata[WID_W-1:0];
        REG_MIDDLE_MODE:  middle_mode    <= cfg_wdata[0];
        REG_LOW_ENABLED:  low_enabled    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_win = (value >= window_base) && (value < window_limit);
    go_low = middle_mode ? (value < window_base) : low_enabled;
    item.stream     = STREAM_HIGH;
    item.below_base = 1'b0;
    offset          = window_limit;
    w_raw           = high_width;
    if (in_win) begin
      item.stream = STREAM_MAIN;
      offset      = window_base;
      w_raw       = main_width;
    end else if (go_low) begin
      item.stream     = STREAM_LOW;
      item.below_base = middle_mode;
      offset          = global_minimum;
      w_raw           = low_width;
    end
    diff    = value - offset;
    w_clamp = (w_raw > FULL_WIDTH) ? FULL_WIDTH : w_raw;
    mask    = (w_clamp == FULL_WIDTH) ? '1 : ((WORD_BITS'(1) << w_clamp) - WORD_BITS'(1));
    item.in_window = in_win;
    item.overflow  = |(diff & ~mask);
    item.bits      = diff & mask;
    item.width     = w_clamp;
    item.last      = last_item;
  end

endmodule

FILE: src/pfep_fifo.sv
module pfep_fifo
  import pfep_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item
);

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/pfep_back.sv
module pfep_back
  import pfep_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  item_t                 head_item,
  output logic                  pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [OUT_USER_W-1:0] m_tuser,
  output logic                  m_tlast
);

  typedef enum logic [2:0] {
    PH_CLASS = 3'b001,
    PH_WORD  = 3'b010,
    PH_FLUSH = 3'b100
  } phase_t;

  phase_t               phase;
  phase_t               phase_next;
  logic [WORD_BITS-1:0] acc  [3];
  logic [FILL_W-1:0]    fill [3];
  logic [WORD_BITS-1:0] word_hold;

  logic                 adv;
  logic [1:0]           flush_idx;
  logic                 flush_more;
  logic [1:0]           sel;
  logic [WORD_BITS-1:0] sel_acc;
  logic [FILL_W-1:0]    sel_fill;
  logic [WID_W-1:0]     sum;
  logic [WID_W-1:0]     spill;
  logic                 word_full;
  logic [WORD_BITS-1:0] pk_word;
  logic [WORD_BITS-1:0] pk_acc;
  logic [FILL_W-1:0]    pk_fill;
  logic                 any_post;
  logic                 any_fill;
  logic                 further;

  logic                 o_kind;
  logic [1:0]           o_stream;
  logic                 o_inw;
  logic                 o_below;
  logic                 o_ovf;
  logic [WORD_BITS-1:0] o_word;
  logic [WID_W-1:0]     o_bits;

  assign adv = head_valid && (!m_tvalid || m_tready);

  always_comb begin
    if (fill[0] != '0) begin
      flush_idx  = STREAM_MAIN;
      flush_more = (fill[1] != '0) || (fill[2] != '0);
    end else if (fill[1] != '0) begin
      flush_idx  = STREAM_LOW;
      flush_more = (fill[2] != '0);
    end else begin
      flush_idx  = STREAM_HIGH;
      flush_more = 1'b0;
    end
    sel      = (phase == PH_FLUSH) ? flush_idx : head_item.stream;
    sel_acc  = acc[sel];
    sel_fill = fill[sel];
    any_fill = (fill[0] != '0) || (fill[1] != '0) || (fill[2] != '0);

    sum       = {1'b0, sel_fill} + head_item.width;
    word_full = (head_item.width != '0) && (sum >= FULL_WIDTH);
    spill     = sum - FULL_WIDTH;
    pk_word   = sel_acc | (head_item.bits >> spill);
    if (word_full) begin
      pk_acc  = head_item.bits << (FULL_WIDTH - spill);
      pk_fill = spill[FILL_W-1:0];
    end else if (head_item.width != '0) begin
      pk_acc  = sel_acc | (head_item.bits << (FULL_WIDTH - sum));
      pk_fill = sum[FILL_W-1:0];
    end else begin
      pk_acc  = sel_acc;
      pk_fill = sel_fill;
    end
    any_post = (pk_fill != '0);
    for (int t = 0; t < 3; t++) begin
      if (2'(t) != head_item.stream && fill[t] != '0) begin
        any_post = 1'b1;
      end
    end

    o_kind     = KIND_WORD;
    o_stream   = head_item.stream;
    o_inw      = 1'b0;
    o_below    = 1'b0;
    o_ovf      = 1'b0;
    o_word     = '0;
    o_bits     = '0;
    further    = 1'b0;
    phase_next = PH_CLASS;
    pop        = 1'b0;
    case (phase)
      PH_CLASS: begin
        o_kind  = KIND_CLASS;
        o_inw   = head_item.in_window;
        o_below = head_item.below_base;
        o_ovf   = head_item.overflow;
        if (word_full) begin
          further    = 1'b1;
          phase_next = PH_WORD;
        end else if (head_item.last && any_post) begin
          further    = 1'b1;
          phase_next = PH_FLUSH;
        end
      end
      PH_WORD: begin
        o_word = word_hold;
        o_bits = FULL_WIDTH;
        if (head_item.last && any_fill) begin
          further    = 1'b1;
          phase_next = PH_FLUSH;
        end
      end
      PH_FLUSH: begin
        o_stream = flush_idx;
        o_word   = sel_acc;
        o_bits   = {1'b0, sel_fill};
        if (flush_more) begin
          further    = 1'b1;
          phase_next = PH_FLUSH;
        end
      end
      default: ;
    endcase
    pop = adv && !further;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_CLASS;
      m_tvalid <= 1'b0;
      for (int t = 0; t < 3; t++) begin
        acc[t]  <= '0;
        fill[t] <= '0;
      end
    end else begin
      if (adv) begin
        phase    <= phase_next;
        m_tvalid <= 1'b1;
        case (phase)
          PH_CLASS: begin
            acc[sel]  <= pk_acc;
            fill[sel] <= pk_fill;
          end
          PH_FLUSH: begin
            acc[sel]  <= '0;
            fill[sel] <= '0;
          end
          default: ;
        endcase
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (phase == PH_CLASS) begin
        word_hold <= pk_word;
      end
      m_tdata <= {{(OUT_DATA_W - 3 - WORD_BITS - WID_W){1'b0}},
                  o_bits, o_word, o_ovf, o_below, o_inw};
      m_tuser <= {o_stream, o_kind};
      m_tlast <= !further;
    end
  end

endmodule

FILE: src/pfor_exception_packer_top.sv
// Channel   Direction  Signals                      Contents (lowest bit first)
// s         in         s_tvalid s_tready s_tdata    tdata: value[63:0]
//                      s_tlast                      tlast: last_item
// m         out        m_tvalid m_tready m_tdata    tdata: in_window, below_base, overflow,
//                      m_tuser m_tlast                     word[63:0], valid_bits[6:0], pad
//                                                   tuser: record_kind, stream[1:0]
// cfg       in         cfg_we cfg_index cfg_wdata   register index 0..7, write on cfg_we
//
// One output transaction per cycle while m is ready; each value causes one to five results,
// issued in turn from the single output register of the packer.
// Classification is combinational into a four-entry queue.
// Reset clears the configuration, the queue and the three stream accumulators.
// A stall on m holds the packer; s stays open until the queue fills.
module pfor_exception_packer_top
  import pfep_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [WORD_BITS-1:0]  cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [WORD_BITS-1:0]  s_tdata,    // value
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,    // in_window, below_base, overflow, word, valid_bits
  output logic [OUT_USER_W-1:0] m_tuser,    // record_kind, stream
  output logic                  m_tlast
);

  item_t front_item;
  item_t head_item;
  logic  q_full;
  logic  head_valid;
  logic  pop;
  logic  push;

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  pfep_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .value     (s_tdata),
    .last_item (s_tlast),
    .item      (front_item)
  );

  pfep_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (front_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  pfep_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule
